// ===== hw/rtl/hsv_blob_centroid_tracker_macros.svh =====
// Assertion macros for the HSV blob centroid tracker.
// Included by the top level; depends on nothing else.
`ifndef HSV_BLOB_CENTROID_TRACKER_MACROS_SVH
`define HSV_BLOB_CENTROID_TRACKER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define HBCT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbct: implication check failed");
`define HBCT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbct: next-cycle check failed");
`else
`define HBCT_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define HBCT_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/hbct_pkg.sv =====
// Shared types and constants of the HSV blob centroid tracker.
// Used by the controller, the datapath and the top level; depends on nothing.
package hbct_pkg;

    localparam int COUNT_W = 21;
    localparam int SUM_W   = 31;
    localparam int QUO_W   = 10;
    localparam int WIN_W   = 9;
    localparam int COORD_W = 10;
    localparam int OFS_W   = 11;
    localparam int STEP_W  = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [WIN_W-1:0]   HUE_LOW_RST     = 9'd11;
    localparam logic [WIN_W-1:0]   HUE_HIGH_RST    = 9'd37;
    localparam logic [WIN_W-1:0]   SAT_LOW_RST     = 9'd75;
    localparam logic [WIN_W-1:0]   SAT_HIGH_RST    = 9'd188;
    localparam logic [WIN_W-1:0]   BRIGHT_LOW_RST  = 9'd202;
    localparam logic [WIN_W-1:0]   BRIGHT_HIGH_RST = 9'd256;
    localparam logic [COORD_W-1:0] AIM_COLUMN_RST  = 10'd350;
    localparam logic [COORD_W-1:0] AIM_ROW_RST     = 10'd230;

    typedef enum logic [2:0] {
        REG_HUE_LOW     = 3'd0,
        REG_HUE_HIGH    = 3'd1,
        REG_SAT_LOW     = 3'd2,
        REG_SAT_HIGH    = 3'd3,
        REG_BRIGHT_LOW  = 3'd4,
        REG_BRIGHT_HIGH = 3'd5,
        REG_AIM_COLUMN  = 3'd6,
        REG_AIM_ROW     = 3'd7
    } reg_idx_t;

    localparam logic KIND_MASK    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_POS   = 2'd1;
    localparam logic [1:0] DIR_NEG   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LOAD = 2'd1,
        ST_DIV  = 2'd2,
        ST_EMIT = 2'd3
    } state_t;

    typedef struct packed {
        logic [WIN_W-1:0]   hue_low;
        logic [WIN_W-1:0]   hue_high;
        logic [WIN_W-1:0]   sat_low;
        logic [WIN_W-1:0]   sat_high;
        logic [WIN_W-1:0]   bright_low;
        logic [WIN_W-1:0]   bright_high;
        logic [COORD_W-1:0] aim_column;
        logic [COORD_W-1:0] aim_row;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic load_div;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

endpackage

// ===== hw/rtl/hsv_blob_centroid_tracker.sv =====
// Latency: a mask result is registered and valid in the cycle after its pixel is accepted; the
// frame summary follows the frame-end pixel through the load, 10-step divide and emit states.
// Throughput: one pixel per cycle while results are taken; a frame-end pixel holds
// the input through the load, the 10-step restoring divide and the emit of the summary.
// Reset: synchronous, active low; config registers return to defaults, sums and count clear.
// Depends on hbct_pkg, hbct_ctrl, hbct_datapath and the assertion macro header.
`include "hsv_blob_centroid_tracker_macros.svh"

module hsv_blob_centroid_tracker #(
    parameter int MAX_DIM    = 1024,
    parameter int MIN_PIXELS = 100
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_hue,
    input  logic [7:0]                    s_saturation,
    input  logic [7:0]                    s_brightness,
    input  logic [hbct_pkg::COORD_W-1:0]  s_column,
    input  logic [hbct_pkg::COORD_W-1:0]  s_row,
    input  logic                          s_frame_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_item_kind,
    output logic                          m_mask_bit,
    output logic                          m_object_found,
    output logic signed [hbct_pkg::OFS_W-1:0] m_offset_x,
    output logic signed [hbct_pkg::OFS_W-1:0] m_offset_y,
    output logic [1:0]                    m_pan_command,
    output logic [1:0]                    m_tilt_command,
    output logic                          m_last_of_run
);

    hbct_pkg::cfg_t     cfg_reg;
    hbct_pkg::reg_idx_t reg_idx;
    hbct_pkg::cmd_t     cmd;
    hbct_pkg::status_t  status;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = hbct_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hue_low     <= hbct_pkg::HUE_LOW_RST;
            cfg_reg.hue_high    <= hbct_pkg::HUE_HIGH_RST;
            cfg_reg.sat_low     <= hbct_pkg::SAT_LOW_RST;
            cfg_reg.sat_high    <= hbct_pkg::SAT_HIGH_RST;
            cfg_reg.bright_low  <= hbct_pkg::BRIGHT_LOW_RST;
            cfg_reg.bright_high <= hbct_pkg::BRIGHT_HIGH_RST;
            cfg_reg.aim_column  <= hbct_pkg::AIM_COLUMN_RST;
            cfg_reg.aim_row     <= hbct_pkg::AIM_ROW_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                hbct_pkg::REG_HUE_LOW:     cfg_reg.hue_low     <= pwdata[8:0];
                hbct_pkg::REG_HUE_HIGH:    cfg_reg.hue_high    <= pwdata[8:0];
                hbct_pkg::REG_SAT_LOW:     cfg_reg.sat_low     <= pwdata[8:0];
                hbct_pkg::REG_SAT_HIGH:    cfg_reg.sat_high    <= pwdata[8:0];
                hbct_pkg::REG_BRIGHT_LOW:  cfg_reg.bright_low  <= pwdata[8:0];
                hbct_pkg::REG_BRIGHT_HIGH: cfg_reg.bright_high <= pwdata[8:0];
                hbct_pkg::REG_AIM_COLUMN:  cfg_reg.aim_column  <= pwdata[9:0];
                hbct_pkg::REG_AIM_ROW:     cfg_reg.aim_row     <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            hbct_pkg::REG_HUE_LOW:     prdata = 32'(cfg_reg.hue_low);
            hbct_pkg::REG_HUE_HIGH:    prdata = 32'(cfg_reg.hue_high);
            hbct_pkg::REG_SAT_LOW:     prdata = 32'(cfg_reg.sat_low);
            hbct_pkg::REG_SAT_HIGH:    prdata = 32'(cfg_reg.sat_high);
            hbct_pkg::REG_BRIGHT_LOW:  prdata = 32'(cfg_reg.bright_low);
            hbct_pkg::REG_BRIGHT_HIGH: prdata = 32'(cfg_reg.bright_high);
            hbct_pkg::REG_AIM_COLUMN:  prdata = 32'(cfg_reg.aim_column);
            hbct_pkg::REG_AIM_ROW:     prdata = 32'(cfg_reg.aim_row);
            default:                   prdata = '0;
        endcase
    end

    hbct_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_frame_end (s_frame_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

    hbct_datapath #(
        .MAX_DIM    (MAX_DIM),
        .MIN_PIXELS (MIN_PIXELS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg            (cfg_reg),
        .s_hue          (s_hue),
        .s_saturation   (s_saturation),
        .s_brightness   (s_brightness),
        .s_column       (s_column),
        .s_row          (s_row),
        .s_frame_end    (s_frame_end),
        .m_item_kind    (m_item_kind),
        .m_mask_bit     (m_mask_bit),
        .m_object_found (m_object_found),
        .m_offset_x     (m_offset_x),
        .m_offset_y     (m_offset_y),
        .m_pan_command  (m_pan_command),
        .m_tilt_command (m_tilt_command),
        .m_last_of_run  (m_last_of_run)
    );

    `HBCT_ASSERT_NEXT(a_frame_end_blocks_input, aclk, aresetn, s_valid && s_ready && s_frame_end, !s_ready)
    `HBCT_ASSERT_IMP(a_summary_is_last, aclk, aresetn, m_valid && m_item_kind == hbct_pkg::KIND_SUMMARY, m_last_of_run && !m_mask_bit)
    `HBCT_ASSERT_IMP(a_mask_no_summary_fields, aclk, aresetn, m_valid && m_item_kind == hbct_pkg::KIND_MASK, !m_object_found && m_pan_command == hbct_pkg::DIR_NONE && m_tilt_command == hbct_pkg::DIR_NONE)
    `HBCT_ASSERT_IMP(a_pan_needs_object, aclk, aresetn, m_valid && m_pan_command != hbct_pkg::DIR_NONE, m_object_found)

endmodule

// ===== hw/rtl/hbct_datapath.sv =====
// Datapath of the HSV blob centroid tracker: window match, accumulators,
// two-lane restoring divider and output register. Depends on hbct_pkg.
module hbct_datapath #(
    parameter int MAX_DIM    = 1024,
    parameter int MIN_PIXELS = 100
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hbct_pkg::cmd_t                cmd,
    output hbct_pkg::status_t             status,
    input  hbct_pkg::cfg_t                cfg,
    input  logic [7:0]                    s_hue,
    input  logic [7:0]                    s_saturation,
    input  logic [7:0]                    s_brightness,
    input  logic [hbct_pkg::COORD_W-1:0]  s_column,
    input  logic [hbct_pkg::COORD_W-1:0]  s_row,
    input  logic                          s_frame_end,
    output logic                          m_item_kind,
    output logic                          m_mask_bit,
    output logic                          m_object_found,
    output logic signed [hbct_pkg::OFS_W-1:0] m_offset_x,
    output logic signed [hbct_pkg::OFS_W-1:0] m_offset_y,
    output logic [1:0]                    m_pan_command,
    output logic [1:0]                    m_tilt_command,
    output logic                          m_last_of_run
);

    localparam logic [12:0] DIM_LIMIT = 13'(MAX_DIM);
    localparam logic [hbct_pkg::COUNT_W-1:0] MIN_COUNT = hbct_pkg::COUNT_W'(MIN_PIXELS);
    localparam int DVS_W = hbct_pkg::COUNT_W + hbct_pkg::QUO_W - 1;

    logic [hbct_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [hbct_pkg::SUM_W-1:0]   col_sum_reg, col_sum_next;
    logic [hbct_pkg::SUM_W-1:0]   row_sum_reg, row_sum_next;

    logic [hbct_pkg::COUNT_W-1:0] div_count_reg;
    logic [DVS_W-1:0]             dvs_reg;
    logic [hbct_pkg::SUM_W-1:0]   col_rem_reg, row_rem_reg;
    logic [hbct_pkg::QUO_W-1:0]   col_quo_reg, row_quo_reg;
    logic [hbct_pkg::STEP_W-1:0]  step_reg;

    logic item_kind_reg, mask_bit_reg, found_reg, last_reg;
    logic [hbct_pkg::OFS_W-1:0] offset_x_reg, offset_y_reg;
    logic [1:0] pan_reg, tilt_reg;

    logic match;
    logic col_ge, row_ge;
    logic [hbct_pkg::SUM_W-1:0] dvs_ext;
    logic found;
    logic [hbct_pkg::OFS_W-1:0] ofs_x, ofs_y;

    assign match = ({1'b0, s_hue} >= cfg.hue_low) && ({1'b0, s_hue} <= cfg.hue_high)
        && ({1'b0, s_saturation} >= cfg.sat_low) && ({1'b0, s_saturation} <= cfg.sat_high)
        && ({1'b0, s_brightness} >= cfg.bright_low)
        && ({1'b0, s_brightness} <= cfg.bright_high)
        && ({3'b0, s_column} < DIM_LIMIT) && ({3'b0, s_row} < DIM_LIMIT);

    assign dvs_ext = {1'b0, dvs_reg};
    assign col_ge  = col_rem_reg >= dvs_ext;
    assign row_ge  = row_rem_reg >= dvs_ext;
    assign status.div_last = (step_reg == '0);

    assign found = div_count_reg > MIN_COUNT;
    assign ofs_x = {1'b0, cfg.aim_column} - {1'b0, col_quo_reg};
    assign ofs_y = {1'b0, cfg.aim_row} - {1'b0, row_quo_reg};

    always_comb begin
        count_next   = count_reg;
        col_sum_next = col_sum_reg;
        row_sum_next = row_sum_reg;
        if (cmd.accept && match && count_reg != hbct_pkg::COUNT_MAX) begin
            count_next   = count_reg + 1'b1;
            col_sum_next = col_sum_reg + hbct_pkg::SUM_W'(s_column);
            row_sum_next = row_sum_reg + hbct_pkg::SUM_W'(s_row);
        end else if (cmd.load_div) begin
            count_next   = '0;
            col_sum_next = '0;
            row_sum_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
        end else begin
            count_reg   <= count_next;
            col_sum_reg <= col_sum_next;
            row_sum_reg <= row_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_div) begin
            div_count_reg <= count_reg;
            dvs_reg       <= {count_reg, {(hbct_pkg::QUO_W-1){1'b0}}};
            col_rem_reg   <= col_sum_reg;
            row_rem_reg   <= row_sum_reg;
            col_quo_reg   <= '0;
            row_quo_reg   <= '0;
            step_reg      <= hbct_pkg::STEP_W'(hbct_pkg::QUO_W - 1);
        end else if (cmd.div_step) begin
            if (col_ge) begin
                col_rem_reg <= col_rem_reg - dvs_ext;
            end
            if (row_ge) begin
                row_rem_reg <= row_rem_reg - dvs_ext;
            end
            col_quo_reg <= {col_quo_reg[hbct_pkg::QUO_W-2:0], col_ge};
            row_quo_reg <= {row_quo_reg[hbct_pkg::QUO_W-2:0], row_ge};
            dvs_reg     <= dvs_reg >> 1;
            step_reg    <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_kind_reg <= hbct_pkg::KIND_MASK;
            mask_bit_reg  <= match;
            found_reg     <= 1'b0;
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
            pan_reg       <= hbct_pkg::DIR_NONE;
            tilt_reg      <= hbct_pkg::DIR_NONE;
            last_reg      <= !s_frame_end;
        end else if (cmd.emit) begin
            item_kind_reg <= hbct_pkg::KIND_SUMMARY;
            mask_bit_reg  <= 1'b0;
            found_reg     <= found;
            last_reg      <= 1'b1;
            if (found) begin
                offset_x_reg <= ofs_x;
                offset_y_reg <= ofs_y;
                pan_reg  <= ofs_x[hbct_pkg::OFS_W-1] ? hbct_pkg::DIR_NEG :
                            (ofs_x != '0) ? hbct_pkg::DIR_POS : hbct_pkg::DIR_NONE;
                tilt_reg <= ofs_y[hbct_pkg::OFS_W-1] ? hbct_pkg::DIR_NEG :
                            (ofs_y != '0) ? hbct_pkg::DIR_POS : hbct_pkg::DIR_NONE;
            end else begin
                offset_x_reg <= '0;
                offset_y_reg <= '0;
                pan_reg      <= hbct_pkg::DIR_NONE;
                tilt_reg     <= hbct_pkg::DIR_NONE;
            end
        end
    end

    assign m_item_kind    = item_kind_reg;
    assign m_mask_bit     = mask_bit_reg;
    assign m_object_found = found_reg;
    assign m_offset_x     = offset_x_reg;
    assign m_offset_y     = offset_y_reg;
    assign m_pan_command  = pan_reg;
    assign m_tilt_command = tilt_reg;
    assign m_last_of_run  = last_reg;

endmodule

// ===== hw/rtl/hbct_ctrl.sv =====
// Controller of the HSV blob centroid tracker: handshakes, output valid
// and sequencing of the end-of-frame divide. Depends on hbct_pkg.
module hbct_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_frame_end,
    output logic              m_valid,
    input  logic              m_ready,
    output hbct_pkg::cmd_t    cmd,
    input  hbct_pkg::status_t status
);

    hbct_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hbct_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            hbct_pkg::ST_IDLE: begin
                s_ready = slot_free;
                if (s_valid && slot_free) begin
                    cmd.accept     = 1'b1;
                    out_valid_next = 1'b1;
                    if (s_frame_end) begin
                        state_next = hbct_pkg::ST_LOAD;
                    end
                end
            end
            hbct_pkg::ST_LOAD: begin
                cmd.load_div = 1'b1;
                state_next   = hbct_pkg::ST_DIV;
            end
            hbct_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = hbct_pkg::ST_EMIT;
                end
            end
            hbct_pkg::ST_EMIT: begin
                if (slot_free) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = hbct_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hbct_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
